[sv/hhe_pkg.sv]
// Shared types, constants and helpers for the HTML hex escape encoder.
package hhe_pkg;

    // Input request: one raw byte of text
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_req_t;

    // Output request: one byte of escaped text
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_req_t;

    // How a byte is to be expanded
    typedef enum logic [1:0] {
        KIND_PASS   = 2'd0,   // byte as is
        KIND_HEX    = 2'd1,   // two hex digits
        KIND_ENTITY = 2'd2    // &#xHH;
    } kind_t;

    // Classified command handed from front end to back end
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    localparam logic MODE_HTML = 1'b0;
    localparam logic MODE_HEX  = 1'b1;

    // Lower-case hex digit for a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h57 + {4'd0, nib};
        end
        return r;
    endfunction

endpackage

[sv/html_hex_escape_encoder.sv]
// Top level of the HTML hex escape encoder: front end, command queue, back end.
//
// Takes one text byte per input request and gives its escaped form as a run of
// output requests, one byte each. With escape_mode 0 (HTML), control bytes,
// '&', '<', '>' and bytes 0x7F-0xFF become "&#xHH;" (six requests) and all
// other bytes pass through as one request; with escape_mode 1 every byte
// becomes two lower-case hex digits, high nibble first. run_last marks the
// final byte of each run and string_end the final byte of a string (the run
// of an input marked in_last). A zero byte is escaped like any other.
// Rate: the back end sends one output byte per cycle while the output is not
// stalled, and the input side takes one request per cycle while the four-entry
// command queue has room. A request taken is written into the command queue,
// and its first output byte is then loaded into the output register. Write
// escape_mode through cfg_wr_en/cfg_wr_data only while the block is idle.
module html_hex_escape_encoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  hhe_pkg::in_req_t  s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output hhe_pkg::out_req_t m_req
);
    import hhe_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    // front end: mode register and byte classification
    hhe_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // queue decouples input stalls from output expansion
    hhe_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back end: byte sequencer and output register
    hhe_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_req       (m_req)
    );

endmodule

[sv/hhe_classify.sv]
// Front end: holds the mode register and classifies each input request.
module hhe_classify (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  hhe_pkg::in_req_t s_req,
    input  logic            q_full,
    output logic            q_push,
    output hhe_pkg::cmd_t   q_cmd
);
    import hhe_pkg::*;

    logic  mode_reg;
    logic  mode_next;
    logic  needs_esc;
    kind_t kind;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_wr_en) begin
            mode_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HTML;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // controls, DEL and above, and the three markup characters
    assign needs_esc = (s_req.in_byte < CHAR_SPACE) || (s_req.in_byte >= CHAR_DEL) ||
                       (s_req.in_byte == CHAR_AMP) || (s_req.in_byte == CHAR_LT) ||
                       (s_req.in_byte == CHAR_GT);

    always_comb begin
        if (mode_reg == MODE_HEX) begin
            kind = KIND_HEX;
        end else if (needs_esc) begin
            kind = KIND_ENTITY;
        end else begin
            kind = KIND_PASS;
        end
    end

    assign s_ready    = !q_full;
    assign q_push     = s_valid && !q_full;
    assign q_cmd.kind = kind;
    assign q_cmd.data = s_req.in_byte;
    assign q_cmd.last = s_req.in_last;

endmodule

[sv/hhe_cmd_fifo.sv]
// Short command queue between the front and back ends.
module hhe_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hhe_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output hhe_pkg::cmd_t head
);
    import hhe_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/hhe_emit.sv]
// Back end: walks each command through its output bytes into an output register.
module hhe_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  hhe_pkg::cmd_t    q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output hhe_pkg::out_req_t m_req
);
    import hhe_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       m_valid_reg, m_valid_next;
    out_req_t   m_req_reg, m_req_next;
    logic       load;
    logic       run_end;
    logic [2:0] end_pos;
    logic [7:0] hi_dig, lo_dig;
    logic [7:0] sel_byte;

    assign hi_dig = hex_digit(q_head.data[7:4]);
    assign lo_dig = hex_digit(q_head.data[3:0]);

    always_comb begin
        case (q_head.kind)
            KIND_PASS:   end_pos = 3'd0;
            KIND_HEX:    end_pos = 3'd1;
            KIND_ENTITY: end_pos = 3'd5;
            default:     end_pos = 3'd0;
        endcase
    end

    always_comb begin
        sel_byte = q_head.data;
        case (q_head.kind)
            KIND_HEX: begin
                sel_byte = (pos_reg == 3'd0) ? hi_dig : lo_dig;
            end
            KIND_ENTITY: begin
                case (pos_reg)
                    3'd0:    sel_byte = CHAR_AMP;
                    3'd1:    sel_byte = CHAR_HASH;
                    3'd2:    sel_byte = CHAR_X;
                    3'd3:    sel_byte = hi_dig;
                    3'd4:    sel_byte = lo_dig;
                    default: sel_byte = CHAR_SEMI;
                endcase
            end
            default: sel_byte = q_head.data;
        endcase
    end

    assign load    = q_not_empty && (!m_valid_reg || m_ready);
    assign run_end = (pos_reg == end_pos);
    assign q_pop   = load && run_end;

    always_comb begin
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_req_next   = m_req_reg;
        if (load) begin
            m_valid_next          = 1'b1;
            m_req_next.out_byte   = sel_byte;
            m_req_next.run_last   = run_end;
            m_req_next.string_end = run_end && q_head.last;
            pos_next              = run_end ? 3'd0 : pos_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_req_reg <= m_req_next;
    end

    assign m_valid = m_valid_reg;
    assign m_req   = m_req_reg;

endmodule

[sv/hhe_checker.sv]
// Port-level checker for the HTML hex escape encoder, bound to the top level.
module hhe_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input hhe_pkg::out_req_t m_req
);
    import hhe_pkg::*;

    // stalled output request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_req))
        else $error("output request changed while stalled");

    // string end only ever on the last byte of a run
    a_end_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_req.string_end || m_req.run_last))
        else $error("string_end without run_last");

    // a run, once begun, continues without a gap
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_req.run_last |=> m_valid)
        else $error("gap inside an escape run");

    // nothing is offered straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind html_hex_escape_encoder hhe_checker u_hhe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_req   (m_req)
);
